FILE: design/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;

    // Fixed field widths.
    localparam int IN_W   = 16;
    localparam int SUM_W  = 40;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int PADR_W = 4;
    localparam int PDAT_W = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    // Raw dimension registers as written.
    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_dim;
        logic [DIM_W-1:0] cols_b;
    } t_dims;

    // Control tag that travels with one multiply through the MAC pipeline.
    typedef struct packed {
        logic             v;
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

    // Last index of a dimension: zero acts as one, anything above the
    // maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] dim_last(logic [DIM_W-1:0] r,
                                                  int unsigned max_dim);
        logic [DIM_W-1:0] res;
        if (r == '0) begin
            res = '0;
        end else if (int'(r) > int'(max_dim)) begin
            res = DIM_W'(max_dim - 1);
        end else begin
            res = r - DIM_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/mm_regs.sv
// Configuration registers behind an APB-style port.
// Depends on mm_pkg for register indexes and the dimension struct.
`default_nettype none

module mm_regs
    import mm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PADR_W-1:0] paddr,
    input  wire logic [PDAT_W-1:0] pwdata,
    output logic      [PDAT_W-1:0] prdata,
    output logic                   pready,
    output t_dims                  o_dims
);

    t_dims            r_dims;
    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [DIM_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows_a    <= DIM_RESET;
            r_dims.inner_dim <= DIM_RESET;
            r_dims.cols_b    <= DIM_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROWS_A:    r_dims.rows_a    <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: r_dims.inner_dim <= pwdata[DIM_W-1:0];
                REG_COLS_B:    r_dims.cols_b    <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_idx)
            REG_ROWS_A:    rd_val = r_dims.rows_a;
            REG_INNER_DIM: rd_val = r_dims.inner_dim;
            REG_COLS_B:    rd_val = r_dims.cols_b;
            default:       rd_val = '0;
        endcase
    end

    assign prdata = {{(PDAT_W-DIM_W){1'b0}}, rd_val};
    assign o_dims = r_dims;

endmodule

`default_nettype wire

FILE: design/mm_store.sv
// Element memories for matrices A and B, one write and one read port each.
// Read data is registered. Depends on mm_pkg.
`default_nettype none

module mm_store
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    parameter int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we_a,
    input  wire logic                        i_we_b,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [ELEM_BITS-1:0]        i_wdata,
    input  wire logic [AW-1:0]               i_raddr_a,
    input  wire logic [AW-1:0]               i_raddr_b,
    output logic signed [ELEM_BITS-1:0]      o_rdata_a,
    output logic signed [ELEM_BITS-1:0]      o_rdata_b
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEM_BITS-1:0] r_mem_a [DEPTH];
    logic [ELEM_BITS-1:0] r_mem_b [DEPTH];

    // Matrix A store.
    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem_a[i_raddr_a];
    end

    // Matrix B store.
    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        o_rdata_b <= r_mem_b[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: design/mm_seq.sv
// Sequencer: takes input beats, writes loads into the stores and walks
// the i, j, k loops of a compute run. Depends on mm_pkg.
`default_nettype none

module mm_seq
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    parameter int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_action,
    input  wire logic [IDX_W-1:0]        i_row_index,
    input  wire logic [IDX_W-1:0]        i_col_index,
    input  wire logic signed [IN_W-1:0]  i_elem_value,
    input  wire t_dims                   i_dims,
    input  wire logic                    i_busy,
    output logic                         o_we_a,
    output logic                         o_we_b,
    output logic [AW-1:0]                o_waddr,
    output logic [ELEM_BITS-1:0]         o_wdata,
    output logic [AW-1:0]                o_raddr_a,
    output logic [AW-1:0]                o_raddr_b,
    output t_tag                         o_tag
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_state        r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_mlast, n_mlast;
    logic [IW-1:0] r_nlast, n_nlast;
    logic [IW-1:0] r_plast, n_plast;

    logic    accept;
    logic    in_range;
    logic    last_elem;
    t_action act;

    assign act       = t_action'(i_action);
    assign accept    = i_in_valid && o_in_ready;
    assign in_range  = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign last_elem = (r_i == r_mlast) && (r_j == r_plast);

    // Load writes go straight to the stores.
    assign o_we_a  = accept && (act == ACT_LOAD_A) && in_range;
    assign o_we_b  = accept && (act == ACT_LOAD_B) && in_range;
    assign o_waddr = AW'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign o_wdata = ELEM_BITS'(i_elem_value);

    // Operand addresses: A(i,k) and B(k,j).
    assign o_raddr_a = AW'(int'(r_i) * MAX_DIM + int'(r_k));
    assign o_raddr_b = AW'(int'(r_k) * MAX_DIM + int'(r_j));

    // State and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_mlast <= '0;
            r_nlast <= '0;
            r_plast <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_mlast <= n_mlast;
            r_nlast <= n_nlast;
            r_plast <= n_plast;
        end
    end

    // Next state, counters and the tag for the multiply issued this cycle.
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_mlast    = r_mlast;
        n_nlast    = r_nlast;
        n_plast    = r_plast;
        o_in_ready = 1'b0;
        o_tag      = '0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && (act == ACT_COMPUTE)) begin
                    n_mlast = IW'(dim_last(i_dims.rows_a, MAX_DIM));
                    n_nlast = IW'(dim_last(i_dims.inner_dim, MAX_DIM));
                    n_plast = IW'(dim_last(i_dims.cols_b, MAX_DIM));
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = S_ISSUE;
                end
            end

            S_ISSUE: begin
                o_tag.v     = 1'b1;
                o_tag.first = (r_k == '0);
                o_tag.lastk = (r_k == r_nlast);
                o_tag.row   = IDX_W'(r_i);
                o_tag.col   = IDX_W'(r_j);
                o_tag.last  = last_elem;
                if (r_k == r_nlast) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end

            S_WAIT: begin
                // Hold until the sum has left the accumulator.
                if (!i_busy) begin
                    if (last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_j == r_plast) begin
                            n_j = '0;
                            n_i = r_i + IW'(1);
                        end else begin
                            n_j = r_j + IW'(1);
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/mm_mac.sv
// Shared multiply-accumulate unit with its result output register.
// Depends on mm_pkg for the tag struct and the sum width.
`default_nettype none

module mm_mac
    import mm_pkg::*;
#(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_tag                        i_tag,
    input  wire logic signed [ELEM_BITS-1:0] i_rdata_a,
    input  wire logic signed [ELEM_BITS-1:0] i_rdata_b,
    output logic                             o_busy,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [IDX_W-1:0]                 o_out_row,
    output logic [IDX_W-1:0]                 o_out_col,
    output logic signed [SUM_W-1:0]          o_dot_sum,
    output logic                             o_last
);

    t_tag                            r_t1;
    t_tag                            r_t2;
    logic signed [2*ELEM_BITS-1:0]   r_prod;
    logic signed [SUM_W-1:0]         r_acc;
    logic                            r_done;
    logic [IDX_W-1:0]                r_row;
    logic [IDX_W-1:0]                r_col;
    logic                            r_last;
    logic                            r_ov;

    logic signed [SUM_W-1:0]         prod_ext;
    logic signed [SUM_W-1:0]         n_acc;
    logic                            move_out;

    assign prod_ext = SUM_W'(r_prod);
    assign n_acc    = r_t2.first ? prod_ext : r_acc + prod_ext;
    assign move_out = r_done && (!r_ov || i_out_ready);
    assign o_busy   = r_t1.v || r_t2.v || r_done;

    // Tag pipeline, aligned with the registered store read and the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
        end
    end

    // Multiplier stage.
    always_ff @(posedge i_clk) begin
        if (r_t1.v) begin
            r_prod <= i_rdata_a * i_rdata_b;
        end
    end

    // Accumulator; holds a finished sum until the output register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            if (move_out) begin
                r_done <= 1'b0;
            end
            if (r_t2.v) begin
                r_done <= r_t2.lastk;
            end
        end
        if (r_t2.v) begin
            r_acc <= n_acc;
            r_row <= r_t2.row;
            r_col <= r_t2.col;
            r_last <= r_t2.last;
        end
    end

    // Output register; the next sum can be built while a beat waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (move_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (move_out) begin
            o_out_row <= r_row;
            o_out_col <= r_col;
            o_dot_sum <= r_acc;
            o_last    <= r_last;
        end
    end

    assign o_out_valid = r_ov;

endmodule

`default_nettype wire

FILE: design/matrix_multiply.sv
// Top level of the matrix multiply block; depends on mm_pkg, mm_regs,
// mm_store, mm_seq and mm_mac.
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_ready    i_action, i_row_index, i_col_index,
//                                        i_elem_value
//   output    o_out_valid / i_out_ready  o_out_row, o_out_col, o_dot_sum, o_last
//   config    psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// Loads stream at one per clock whenever no compute run is in progress.
// A compute beat runs m*p result elements; each one takes n issues through
// the single multiplier, then store read, product, accumulate and hand-off,
// and o_in_ready stays low for the whole run.
// Reset clears control state only; the element stores are undefined until
// loaded, and there is no clearing pass.
// A stalled output holds one finished beat while the next sum is built.
`default_nettype none

module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_action,
    input  wire logic [IDX_W-1:0]        i_row_index,
    input  wire logic [IDX_W-1:0]        i_col_index,
    input  wire logic signed [IN_W-1:0]  i_elem_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [IDX_W-1:0]             o_out_row,
    output logic [IDX_W-1:0]             o_out_col,
    output logic signed [SUM_W-1:0]      o_dot_sum,
    output logic                         o_last,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADR_W-1:0]       paddr,
    input  wire logic [PDAT_W-1:0]       pwdata,
    output logic      [PDAT_W-1:0]       prdata,
    output logic                         pready
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    t_dims                       dims;
    t_tag                        tag;
    logic                        busy;
    logic                        we_a;
    logic                        we_b;
    logic [AW-1:0]               waddr;
    logic [ELEM_BITS-1:0]        wdata;
    logic [AW-1:0]               raddr_a;
    logic [AW-1:0]               raddr_b;
    logic signed [ELEM_BITS-1:0] rdata_a;
    logic signed [ELEM_BITS-1:0] rdata_b;

    // Configuration registers.
    mm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    // Loop sequencer.
    mm_seq #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS),
        .AW        (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .i_dims       (dims),
        .i_busy       (busy),
        .o_we_a       (we_a),
        .o_we_b       (we_b),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b),
        .o_tag        (tag)
    );

    // Element stores.
    mm_store #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we_a    (we_a),
        .i_we_b    (we_b),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Multiply-accumulate unit and output register.
    mm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (tag),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_dot_sum   (o_dot_sum),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: design/mm_chk.sv
// Port-level checks for the matrix multiply block, bound to its top level.
// Depends on mm_pkg for the action codes and field widths.
`default_nettype none

module mm_chk
    import mm_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire logic [1:0]             i_action,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic signed [SUM_W-1:0] o_dot_sum,
    input wire logic                   o_last
);

    // Reset leaves no result beat pending.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result beat holds its sum.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_dot_sum))
        else $error("stalled result beat changed");

    // A compute beat closes the input until the run is done.
    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_COMPUTE) |=> !o_in_ready)
        else $error("input ready straight after a compute beat");

    // While a run still has results to come, no new beat is taken.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready in the middle of a run");

endmodule

bind matrix_multiply mm_chk u_mm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_dot_sum   (o_dot_sum),
    .o_last      (o_last)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the matrix multiply block: loads elements, runs products
// under several dimension settings and idling patterns, and checks every result beat.
// Depends on mm_pkg and matrix_multiply.

module testbench;
    import mm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int QUIET_CYCLES = 24;

    // One element of the product as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_product_elem;

    // Mirrors the dimension registers and element stores, and keeps the
    // products still due in the order the block emits them.
    class matmul_scoreboard;
        logic [DIM_W-1:0]       dim_raw [3];
        logic signed [IN_W-1:0] mat_a [MAX_DIM_DEF*MAX_DIM_DEF];
        logic signed [IN_W-1:0] mat_b [MAX_DIM_DEF*MAX_DIM_DEF];
        t_product_elem          expected_elems [$];
        int                     mismatches;
        int                     stray;

        function new();
            dim_raw[REG_ROWS_A]    = DIM_RESET;
            dim_raw[REG_INNER_DIM] = DIM_RESET;
            dim_raw[REG_COLS_B]    = DIM_RESET;
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            mismatches = 0;
            stray      = 0;
        endfunction

        // A zero register acts as one, anything above the maximum as the maximum.
        function int unsigned eff_dim(logic [DIM_W-1:0] r);
            if (r == '0) begin
                return 1;
            end
            if (int'(r) > MAX_DIM_DEF) begin
                return MAX_DIM_DEF;
            end
            return int'(r);
        endfunction

        function void write_dim(logic [1:0] idx, logic [PDAT_W-1:0] data);
            if (idx <= REG_COLS_B) begin
                dim_raw[idx] = data[DIM_W-1:0];
            end
        endfunction

        // Queue every element of C in row-major order, the final one marked.
        function void predict_product();
            int unsigned             m;
            int unsigned             n;
            int unsigned             p;
            logic signed [SUM_W-1:0] acc;
            t_product_elem           e;
            m = eff_dim(dim_raw[REG_ROWS_A]);
            n = eff_dim(dim_raw[REG_INNER_DIM]);
            p = eff_dim(dim_raw[REG_COLS_B]);
            for (int i = 0; i < m; i++) begin
                for (int j = 0; j < p; j++) begin
                    acc = '0;
                    for (int k = 0; k < n; k++) begin
                        acc = acc + mat_a[i*MAX_DIM_DEF+k] * mat_b[k*MAX_DIM_DEF+j];
                    end
                    e.row  = IDX_W'(i);
                    e.col  = IDX_W'(j);
                    e.sum  = acc;
                    e.last = (i == m - 1) && (j == p - 1);
                    expected_elems.push_back(e);
                end
            end
        endfunction

        // Called for every accepted input beat.
        function void note_beat(logic [1:0] act, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic signed [IN_W-1:0] value);
            case (act)
                ACT_LOAD_A:  mat_a[{row, col}] = value;
                ACT_LOAD_B:  mat_b[{row, col}] = value;
                ACT_COMPUTE: predict_product();
                default: ;
            endcase
        endfunction

        // Called for every accepted output beat.
        function void check_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                    logic signed [SUM_W-1:0] sum, logic last);
            t_product_elem e;
            if (expected_elems.size() == 0) begin
                stray++;
                if (mismatches + stray <= 10) begin
                    $display("unexpected element: row %0d col %0d sum %0d last %0b",
                             row, col, sum, last);
                end
                return;
            end
            e = expected_elems.pop_front();
            if (e.row !== row || e.col !== col || e.sum !== sum || e.last !== last) begin
                mismatches++;
                if (mismatches + stray <= 10) begin
                    $display("element mismatch: expected row %0d col %0d sum %0d last %0b",
                             e.row, e.col, e.sum, e.last);
                    $display("                  got      row %0d col %0d sum %0d last %0b",
                             row, col, sum, last);
                end
            end
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        function int failures();
            return mismatches + stray + expected_elems.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_action = ACT_LOAD_A;
    logic [IDX_W-1:0]        i_row_index = '0;
    logic [IDX_W-1:0]        i_col_index = '0;
    logic signed [IN_W-1:0]  i_elem_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [IDX_W-1:0]        o_out_row;
    logic [IDX_W-1:0]        o_out_col;
    logic signed [SUM_W-1:0] o_dot_sum;
    logic                    o_last;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADR_W-1:0]       paddr = '0;
    logic [PDAT_W-1:0]       pwdata = '0;
    logic [PDAT_W-1:0]       prdata;
    logic                    pready;

    matmul_scoreboard sb;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  work_beats = 0;
    int  cycle_count = 0;
    bit  loaded_a [MAX_DIM_DEF*MAX_DIM_DEF];
    bit  loaded_b [MAX_DIM_DEF*MAX_DIM_DEF];

    matrix_multiply uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_dot_sum    (o_dot_sum),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure, and a check of every accepted beat.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_element(o_out_row, o_out_col, o_dot_sum, o_last);
        end
    end

    // Element values lean towards the extremes now and then.
    function automatic logic [IN_W-1:0] rand_elem();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return 16'h7FFF;
        end else if (r < 8) begin
            return 16'h8000;
        end else if (r < 11) begin
            return 16'hFFFF;
        end else if (r < 14) begin
            return 16'h0000;
        end
        return IN_W'($urandom());
    endfunction

    // Mostly small dimensions, with the out-of-range codes and the maximum now and then.
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return '0;
        end else if (r < 14) begin
            return DIM_W'($urandom_range(15, 9));
        end else if (r < 22) begin
            return DIM_W'(MAX_DIM_DEF);
        end
        return DIM_W'($urandom_range(4, 1));
    endfunction

    // Present one input beat, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_beat(input logic [1:0] act, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [IN_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_row_index  <= row;
        i_col_index  <= col;
        i_elem_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(act, row, col, value);
        if (act == ACT_LOAD_A) begin
            loaded_a[{row, col}] = 1'b1;
        end else if (act == ACT_LOAD_B) begin
            loaded_b[{row, col}] = 1'b1;
        end
        if (act != ACT_UNUSED) begin
            work_beats++;
        end
    endtask

    // Stop sending and wait until every queued product element has arrived.
    task automatic drain_products();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Leave the block idle before touching its registers.
    task automatic settle();
        drain_products();
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Register write with a setup and an access phase; the upper data bits are junk the block must drop.
    task automatic reg_write(input logic [1:0] idx, input logic [DIM_W-1:0] value);
        logic [PDAT_W-1:0] word;
        word = $urandom();
        word[DIM_W-1:0] = value;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_dim(idx, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols);
        reg_write(REG_ROWS_A, rows);
        reg_write(REG_INNER_DIM, inner);
        reg_write(REG_COLS_B, cols);
    endtask

    // Load any element the next product reads that has never been written, then compute.
    task automatic compute_run();
        int unsigned m;
        int unsigned n;
        int unsigned p;
        m = sb.eff_dim(sb.dim_raw[REG_ROWS_A]);
        n = sb.eff_dim(sb.dim_raw[REG_INNER_DIM]);
        p = sb.eff_dim(sb.dim_raw[REG_COLS_B]);
        for (int i = 0; i < m; i++) begin
            for (int k = 0; k < n; k++) begin
                if (!loaded_a[i*MAX_DIM_DEF+k]) begin
                    send_beat(ACT_LOAD_A, IDX_W'(i), IDX_W'(k), rand_elem());
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < p; j++) begin
                if (!loaded_b[k*MAX_DIM_DEF+j]) begin
                    send_beat(ACT_LOAD_B, IDX_W'(k), IDX_W'(j), rand_elem());
                end
            end
        end
        send_beat(ACT_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                  rand_elem());
    endtask

    // Random traffic: mostly loads inside the active dimensions, some loads anywhere,
    // some ignored beats and a product now and then; always ends with a product.
    task automatic run_phase(input int budget, input bit pressure);
        int          target;
        int          r;
        bit          hold_pending;
        int unsigned m;
        int unsigned n;
        int unsigned p;
        target       = work_beats + budget;
        hold_pending = pressure;
        m = sb.eff_dim(sb.dim_raw[REG_ROWS_A]);
        n = sb.eff_dim(sb.dim_raw[REG_INNER_DIM]);
        p = sb.eff_dim(sb.dim_raw[REG_COLS_B]);
        while (work_beats < target) begin
            if (hold_pending && work_beats >= target - budget / 2) begin
                hold_pending = 1'b0;
                drain_products();
            end
            r = $urandom_range(99);
            if (r < 12) begin
                compute_run();
            end else if (r < 17) begin
                send_beat(ACT_UNUSED, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                          rand_elem());
            end else if (r < 27) begin
                send_beat(2'($urandom_range(1)), IDX_W'($urandom_range(7)),
                          IDX_W'($urandom_range(7)), rand_elem());
            end else if (r < 64) begin
                send_beat(ACT_LOAD_A, IDX_W'($urandom_range(m - 1)),
                          IDX_W'($urandom_range(n - 1)), rand_elem());
            end else begin
                send_beat(ACT_LOAD_B, IDX_W'($urandom_range(n - 1)),
                          IDX_W'($urandom_range(p - 1)), rand_elem());
            end
        end
        compute_run();
    endtask

    initial begin
        sb = new();
        foreach (loaded_a[i]) begin
            loaded_a[i] = 1'b0;
            loaded_b[i] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 2x2 product over the extreme element values.
        set_dims(4'd2, 4'd2, 4'd2);
        send_beat(ACT_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
        send_beat(ACT_LOAD_A, 3'd0, 3'd1, 16'h8000);
        send_beat(ACT_LOAD_A, 3'd1, 3'd0, 16'hFFFF);
        send_beat(ACT_LOAD_A, 3'd1, 3'd1, 16'h0000);
        send_beat(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
        send_beat(ACT_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
        send_beat(ACT_LOAD_B, 3'd1, 3'd0, 16'h8000);
        send_beat(ACT_LOAD_B, 3'd1, 3'd1, 16'h0001);
        // Corner indexes outside the active dimensions, then an ignored action.
        send_beat(ACT_LOAD_A, 3'd7, 3'd7, 16'h5555);
        send_beat(ACT_LOAD_B, 3'd7, 3'd7, 16'hAAAA);
        send_beat(ACT_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        send_beat(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);

        // Zero dimensions act as one.
        settle();
        set_dims(4'd0, 4'd0, 4'd0);
        compute_run();

        // Oversized rows act as the maximum: a single column of eight.
        settle();
        set_dims(4'd15, 4'd1, 4'd1);
        compute_run();

        // Random phases, each with its own dimensions and idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 6 : 0;
            stall_pct = (ph == 2) ? 49 : (ph == 3) ? 6 : 0;
            if (ph == 2) begin
                set_dims(4'd8, 4'd15, 4'd9);
            end else begin
                set_dims(pick_dim(), pick_dim(), pick_dim());
            end
            run_phase(30, ph == 3);
        end

        drain_products();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (sb.failures() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mm_pkg.sv
design/mm_regs.sv
design/mm_store.sv
design/mm_seq.sv
design/mm_mac.sv
design/matrix_multiply.sv
design/mm_chk.sv
tb/testbench.sv
